// ===== src/cdt_pkg.sv =====
// shared types and constants for the connection demux table
package cdt_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    localparam logic [2:0] K_EXACT = 3'd0;
    localparam logic [2:0] K_PA    = 3'd1;
    localparam logic [2:0] K_PORT  = 3'd2;
    localparam logic [2:0] K_ADDR  = 3'd3;
    localparam logic [2:0] K_ANY   = 3'd4;

    // one classified command, as queued between front and back
    typedef struct packed {
        t_cmd        cmd;
        logic [63:0] rh;
        logic [63:0] rl;
        logic [15:0] rp;
        logic [63:0] lh;
        logic [63:0] ll;
        logic [15:0] lp;
        logic [9:0]  id;
        logic [2:0]  kind;
        logic [31:0] h_exact;
        logic [31:0] h_pa;
        logic [31:0] h_port;
        logic [31:0] h_addr;
    } t_job;

    // stored entry
    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] rh;
        logic [63:0] rl;
        logic [63:0] lh;
        logic [63:0] ll;
        logic [31:0] ports;
        logic [9:0]  conn;
    } t_slot;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_FILL,
        BS_READ,
        BS_CHECK,
        BS_SHIFT,
        BS_WRITE,
        BS_DONE
    } t_bstate;

    function automatic logic [31:0] hash32(input logic [7:0] ra, input logic [15:0] rp,
                                           input logic [7:0] la, input logic [15:0] lp);
        hash32 = {ra, 24'd0} ^ {rp, 16'd0} ^ {16'd0, la, 8'd0} ^ {16'd0, lp};
    endfunction

endpackage

// ===== src/cdt_front.sv =====
// front end: classifies and hashes commands into a two entry queue
module cdt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  cdt_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output cdt_pkg::t_job o_job,
    input  logic          i_pop
);
    cdt_pkg::t_job r_q [2];
    logic [1:0]    r_cnt;
    logic          r_rd;
    logic          r_wr;
    cdt_pkg::t_job w_job;
    logic          rz;
    logic          lz;

    assign rz = (i_job.rh == 64'd0) && (i_job.rl == 64'd0);
    assign lz = (i_job.lh == 64'd0) && (i_job.ll == 64'd0);

    always_comb begin
        w_job = i_job;
        if (!rz) begin
            w_job.kind = cdt_pkg::K_EXACT;
        end else if (!lz) begin
            w_job.kind = (i_job.lp == 16'd0) ? cdt_pkg::K_ADDR : cdt_pkg::K_PA;
        end else begin
            w_job.kind = (i_job.lp == 16'd0) ? cdt_pkg::K_ANY : cdt_pkg::K_PORT;
        end
        w_job.h_exact = cdt_pkg::hash32(i_job.rl[7:0], i_job.rp, i_job.ll[7:0], i_job.lp);
        w_job.h_pa    = cdt_pkg::hash32(8'd0, 16'd0, i_job.ll[7:0], i_job.lp);
        w_job.h_port  = cdt_pkg::hash32(8'd0, 16'd0, 8'd0, i_job.lp);
        w_job.h_addr  = cdt_pkg::hash32(8'd0, 16'd0, i_job.ll[7:0], 16'd0);
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_q[r_wr] <= w_job;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (i_take) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_take} - {1'b0, i_pop};
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    a_take_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> r_cnt != 2'd2) else $error("take into full queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
endmodule

// ===== src/cdt_back.sv =====
// back end: walks buckets in the slot memory, reading one slot at a time
module cdt_back #(
    parameter int BUCKETS = 64,
    parameter int WAYS    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cdt_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_strobe,
    output logic [1:0]    o_status,
    output logic [9:0]    o_found_conn,
    output logic [2:0]    o_match_kind
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FW = $clog2(WAYS + 1);
    localparam int AW = BW + WW;

    cdt_pkg::t_slot r_mem [BUCKETS*WAYS];
    logic [FW-1:0]  r_fill [BUCKETS];

    cdt_pkg::t_bstate r_st, n_st;
    cdt_pkg::t_job    r_job;
    logic [2:0]       r_pass, n_pass;
    logic [BW-1:0]    r_b, n_b;
    logic [FW-1:0]    r_i, n_i;
    logic [FW-1:0]    r_n, n_n;
    logic [BW-1:0]    r_clr, n_clr;
    cdt_pkg::t_slot   r_rdat;
    logic [FW-1:0]    r_fdat;
    logic [1:0]       r_status, n_status;
    logic [9:0]       r_found, n_found;
    logic [2:0]       r_kind, n_kind;

    logic [AW-1:0]    w_raddr;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    cdt_pkg::t_slot   w_wdat;
    logic             w_fwe;
    logic [BW-1:0]    w_fwaddr;
    logic [FW-1:0]    w_fval;
    logic             w_hit;
    logic [2:0]       w_pk;
    cdt_pkg::t_slot   w_new;

    function automatic logic [BW-1:0] bsel(input logic [31:0] h);
        bsel = BW'(h % BUCKETS);
    endfunction

    function automatic logic [AW-1:0] sa(input logic [BW-1:0] b, input logic [FW-1:0] w);
        sa = AW'(b * WAYS + w);
    endfunction

    always_comb begin
        unique case (r_pass)
            3'd0: w_pk = cdt_pkg::K_EXACT;
            3'd1: w_pk = cdt_pkg::K_PA;
            3'd2: w_pk = cdt_pkg::K_PORT;
            3'd3: w_pk = cdt_pkg::K_ADDR;
            default: w_pk = cdt_pkg::K_ANY;
        endcase
    end

    always_comb begin
        w_hit = 1'b0;
        if (r_job.cmd == cdt_pkg::CMD_REMOVE) begin
            w_hit = (r_rdat.conn == r_job.id);
        end else if (r_rdat.kind == w_pk) begin
            w_hit = 1'b1;
            if (w_pk == cdt_pkg::K_EXACT && (r_rdat.rh != r_job.rh || r_rdat.rl != r_job.rl
                || r_rdat.ports[31:16] != r_job.rp)) begin
                w_hit = 1'b0;
            end
            if ((w_pk == cdt_pkg::K_EXACT || w_pk == cdt_pkg::K_PA || w_pk == cdt_pkg::K_ADDR)
                && (r_rdat.lh != r_job.lh || r_rdat.ll != r_job.ll)) begin
                w_hit = 1'b0;
            end
            if ((w_pk == cdt_pkg::K_EXACT || w_pk == cdt_pkg::K_PA || w_pk == cdt_pkg::K_PORT)
                && r_rdat.ports[15:0] != r_job.lp) begin
                w_hit = 1'b0;
            end
        end
    end

    always_comb begin
        w_new.kind  = r_job.kind;
        w_new.rh    = r_job.rh;
        w_new.rl    = r_job.rl;
        w_new.lh    = r_job.lh;
        w_new.ll    = r_job.ll;
        w_new.ports = {r_job.rp, r_job.lp};
        w_new.conn  = r_job.id;
    end

    // next state and datapath control
    always_comb begin
        n_st = r_st; n_pass = r_pass; n_b = r_b; n_i = r_i; n_n = r_n; n_clr = r_clr;
        n_status = r_status; n_found = r_found; n_kind = r_kind;
        w_raddr = sa(r_b, r_i - FW'(1));
        unique case (r_st)
            cdt_pkg::BS_CLEAR: begin
                n_clr = r_clr + BW'(1);
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_st = cdt_pkg::BS_IDLE;
                end
            end
            cdt_pkg::BS_IDLE: begin
                if (i_valid) begin
                    n_b = bsel(i_job.h_exact);
                    n_pass = 3'd0;
                    n_status = cdt_pkg::ST_NOTFOUND;
                    n_found = 10'd0;
                    n_kind = 3'd0;
                    unique case (i_job.cmd) inside
                        cdt_pkg::CMD_INSERT, cdt_pkg::CMD_REMOVE, cdt_pkg::CMD_LOOKUP:
                            n_st = cdt_pkg::BS_FILL;
                        default: n_st = cdt_pkg::BS_DONE;
                    endcase
                end
            end
            cdt_pkg::BS_FILL: begin
                // fill count of r_b is in r_fdat now
                n_n = r_fdat;
                n_i = r_fdat;
                n_st = (r_job.cmd == cdt_pkg::CMD_INSERT) ? cdt_pkg::BS_WRITE
                                                          : cdt_pkg::BS_READ;
            end
            cdt_pkg::BS_READ: begin
                if (r_i == FW'(0)) begin
                    if (r_job.cmd == cdt_pkg::CMD_LOOKUP && r_pass != 3'd4) begin
                        n_pass = r_pass + 3'd1;
                        unique case (r_pass)
                            3'd0: n_b = bsel(r_job.h_pa);
                            3'd1: n_b = bsel(r_job.h_port);
                            3'd2: n_b = bsel(r_job.h_addr);
                            default: n_b = bsel(32'd0);
                        endcase
                        n_st = cdt_pkg::BS_FILL;
                    end else begin
                        n_st = cdt_pkg::BS_DONE;
                    end
                end else begin
                    n_st = cdt_pkg::BS_CHECK;
                end
            end
            cdt_pkg::BS_CHECK: begin
                if (w_hit) begin
                    n_status = cdt_pkg::ST_DONE;
                    if (r_job.cmd == cdt_pkg::CMD_LOOKUP) begin
                        n_found = r_rdat.conn;
                        n_kind = w_pk;
                        n_st = cdt_pkg::BS_DONE;
                    end else begin
                        n_st = cdt_pkg::BS_SHIFT;
                    end
                end else begin
                    n_i = r_i - FW'(1);
                    n_st = cdt_pkg::BS_READ;
                end
            end
            cdt_pkg::BS_SHIFT: begin
                // r_i-1 is the hole; pull the next slot down one
                w_raddr = sa(r_b, r_i);
                if (r_i >= r_n) begin
                    n_st = cdt_pkg::BS_DONE;
                end else begin
                    n_st = cdt_pkg::BS_WRITE;
                end
            end
            cdt_pkg::BS_WRITE: begin
                if (r_job.cmd == cdt_pkg::CMD_INSERT) begin
                    n_status = (r_n >= FW'(WAYS)) ? cdt_pkg::ST_FULL : cdt_pkg::ST_DONE;
                    n_st = cdt_pkg::BS_DONE;
                end else begin
                    n_i = r_i + FW'(1);
                    n_st = cdt_pkg::BS_SHIFT;
                end
            end
            cdt_pkg::BS_DONE: n_st = cdt_pkg::BS_IDLE;
            default: n_st = cdt_pkg::BS_IDLE;
        endcase
    end

    // outputs and write strobes
    always_comb begin
        o_pop = 1'b0; w_we = 1'b0; w_fwe = 1'b0;
        w_waddr = sa(r_b, r_n); w_wdat = w_new; w_fval = r_n; w_fwaddr = r_b;
        o_strobe = 1'b0;
        unique case (r_st)
            cdt_pkg::BS_CLEAR: begin
                w_fwe = 1'b1;
                w_fval = '0;
                w_fwaddr = r_clr;
            end
            cdt_pkg::BS_IDLE: o_pop = i_valid;
            cdt_pkg::BS_WRITE: begin
                if (r_job.cmd == cdt_pkg::CMD_INSERT) begin
                    w_we = (r_n < FW'(WAYS));
                    w_fwe = w_we;
                    w_fval = r_n + FW'(1);
                end else begin
                    w_we = 1'b1;
                    w_waddr = sa(r_b, r_i - FW'(1));
                    w_wdat = r_rdat;
                end
            end
            cdt_pkg::BS_SHIFT: begin
                w_fwe = (r_i >= r_n);
                w_fval = r_n - FW'(1);
            end
            cdt_pkg::BS_DONE: o_strobe = 1'b1;
            default: ;
        endcase
    end

    assign o_status     = r_status;
    assign o_found_conn = r_found;
    assign o_match_kind = r_kind;

    always_ff @(posedge i_clk) begin
        r_rdat <= r_mem[w_raddr];
        if (w_we) begin
            r_mem[w_waddr] <= w_wdat;
        end
    end

    // fill counts: registered read of the bucket being entered
    always_ff @(posedge i_clk) begin
        r_fdat <= r_fill[n_b];
        if (w_fwe) begin
            r_fill[w_fwaddr] <= w_fval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        r_b <= n_b; r_i <= n_i; r_n <= n_n; r_pass <= n_pass;
        r_status <= n_status; r_found <= n_found; r_kind <= n_kind;
        if (!i_rst_n) begin
            r_st  <= cdt_pkg::BS_CLEAR;
            r_clr <= '0;
        end else begin
            r_st  <= n_st;
            r_clr <= n_clr;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fwe |-> w_fval <= FW'(WAYS)) else $error("fill beyond ways");
    a_hit_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != cdt_pkg::ST_DONE)
        |-> (o_found_conn == 10'd0 && o_match_kind == 3'd0))
        else $error("miss carries payload");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_st != cdt_pkg::BS_IDLE) else $error("pop without start");
endmodule

// ===== src/connection_demux_table_top.sv =====
// top level of the connection demux table
//
// channel   dir  handshake                  fields
// command   in   i_start & !o_busy          i_command .. i_conn_id
// result    out  o_done, one cycle          o_status, o_found_conn, o_match_kind
//
// the back takes an unused command straight to done, an insert through a fill count read
// and a write, a remove through the fill read, a newest-first check of each slot and a
// shift of the later slots down, and a lookup through one pass per kind (exact, pa,
// port, addr, any) until one hits, each pass reading one bucket's fill count and then
// its slots, paced by the slot memory's single read port and one fill read per bucket
// the front queue holds two commands so the host can keep issuing
// synchronous active-low reset starts a clearing pass over all BUCKETS fill counts;
// the queue still takes two commands meanwhile
// the receiver cannot stall: each result shows for one cycle
module connection_demux_table_top #(
    parameter int BUCKETS = 64,
    parameter int WAYS    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_remote_addr_hi,
    input  logic [63:0] i_remote_addr_lo,
    input  logic [15:0] i_remote_port,
    input  logic [63:0] i_local_addr_hi,
    input  logic [63:0] i_local_addr_lo,
    input  logic [15:0] i_local_port,
    input  logic [9:0]  i_conn_id,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [9:0]  o_found_conn,
    output logic [2:0]  o_match_kind
);
    cdt_pkg::t_job w_in;
    cdt_pkg::t_job w_q;
    logic          w_full;
    logic          w_valid;
    logic          w_pop;

    // raw fields; classification and hashes fill in the front
    always_comb begin
        w_in      = '0;
        w_in.cmd  = cdt_pkg::t_cmd'(i_command);
        w_in.rh   = i_remote_addr_hi;
        w_in.rl   = i_remote_addr_lo;
        w_in.rp   = i_remote_port;
        w_in.lh   = i_local_addr_hi;
        w_in.ll   = i_local_addr_lo;
        w_in.lp   = i_local_port;
        w_in.id   = i_conn_id;
    end

    assign o_busy = w_full;

    cdt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (i_start && !w_full),
        .i_job   (w_in),
        .o_full  (w_full),
        .o_valid (w_valid),
        .o_job   (w_q),
        .i_pop   (w_pop)
    );

    cdt_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid),
        .i_job        (w_q),
        .o_pop        (w_pop),
        .o_strobe     (o_done),
        .o_status     (o_status),
        .o_found_conn (o_found_conn),
        .o_match_kind (o_match_kind)
    );
endmodule

// ===== test/tb.sv =====
// testbench for the connection demux table: directed and random commands checked against a model
module tb;

    localparam int NB = 64;
    localparam int NW = 4;
    localparam int STALL_LIMIT = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_command;
    logic [63:0] i_remote_addr_hi;
    logic [63:0] i_remote_addr_lo;
    logic [15:0] i_remote_port;
    logic [63:0] i_local_addr_hi;
    logic [63:0] i_local_addr_lo;
    logic [15:0] i_local_port;
    logic [9:0]  i_conn_id;
    logic        o_done;
    logic [1:0]  o_status;
    logic [9:0]  o_found_conn;
    logic [2:0]  o_match_kind;

    connection_demux_table_top #(.BUCKETS(NB), .WAYS(NW)) u_dut (.*);

    // expected response of one command
    typedef struct packed {
        logic [1:0] status;
        logic [9:0] conn;
        logic [2:0] kind;
    } t_resp;

    // model of the table
    logic [2:0]  fill_m [NB];
    logic [2:0]  kind_m [NB][NW];
    logic [63:0] rh_m   [NB][NW];
    logic [63:0] rl_m   [NB][NW];
    logic [63:0] lh_m   [NB][NW];
    logic [63:0] ll_m   [NB][NW];
    logic [15:0] rp_m   [NB][NW];
    logic [15:0] lp_m   [NB][NW];
    logic [9:0]  conn_m [NB][NW];

    t_resp resp_q[$];
    int    errors = 0;
    int    send_idle_pct;
    int    quiet_cycles = 0;

    // pools keep addresses colliding so lookups hit
    logic [63:0] pool_hi[4];
    logic [63:0] pool_lo[4];
    logic [15:0] pool_port[4];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int bucket_of(logic [7:0] ra, logic [15:0] rp, logic [7:0] la,
                                     logic [15:0] lp);
        logic [31:0] h;
        h = ({ra, 24'd0} ^ {rp, 16'd0}) ^ ({16'd0, la, 8'd0} ^ {16'd0, lp});
        return int'(h % NB);
    endfunction

    // search one bucket newest first
    function automatic int find_slot(int b, logic [2:0] k, bit cr, bit cla, bit clp,
                                     logic [63:0] rh, logic [63:0] rl, logic [15:0] rp,
                                     logic [63:0] lh, logic [63:0] ll, logic [15:0] lp);
        for (int i = int'(fill_m[b]) - 1; i >= 0; i--) begin
            if (kind_m[b][i] != k) continue;
            if (cr && (rh_m[b][i] != rh || rl_m[b][i] != rl || rp_m[b][i] != rp)) continue;
            if (cla && (lh_m[b][i] != lh || ll_m[b][i] != ll)) continue;
            if (clp && lp_m[b][i] != lp) continue;
            return i;
        end
        return -1;
    endfunction

    // apply one command to the model and return its response
    function automatic t_resp table_step(cdt_pkg::t_cmd c, logic [63:0] rh, logic [63:0] rl,
                                         logic [15:0] rp, logic [63:0] lh, logic [63:0] ll,
                                         logic [15:0] lp, logic [9:0] id);
        t_resp r;
        int b, s, n;
        logic [2:0] k;
        r = '{status: cdt_pkg::ST_NOTFOUND, conn: '0, kind: '0};
        b = bucket_of(rl[7:0], rp, ll[7:0], lp);
        n = int'(fill_m[b]);
        case (c)
            cdt_pkg::CMD_INSERT: begin
                if (n >= NW) begin
                    r.status = cdt_pkg::ST_FULL;
                end else begin
                    if (rh != 0 || rl != 0) k = cdt_pkg::K_EXACT;
                    else if (lh != 0 || ll != 0) k = (lp == 0) ? cdt_pkg::K_ADDR : cdt_pkg::K_PA;
                    else k = (lp == 0) ? cdt_pkg::K_ANY : cdt_pkg::K_PORT;
                    kind_m[b][n] = k;
                    rh_m[b][n] = rh; rl_m[b][n] = rl; rp_m[b][n] = rp;
                    lh_m[b][n] = lh; ll_m[b][n] = ll; lp_m[b][n] = lp;
                    conn_m[b][n] = id;
                    fill_m[b] = 3'(n + 1);
                    r.status = cdt_pkg::ST_DONE;
                end
            end
            cdt_pkg::CMD_REMOVE: begin
                for (int i = n - 1; i >= 0; i--) begin
                    if (conn_m[b][i] == id) begin
                        for (int j = i; j < n - 1; j++) begin
                            kind_m[b][j] = kind_m[b][j+1];
                            rh_m[b][j] = rh_m[b][j+1]; rl_m[b][j] = rl_m[b][j+1];
                            rp_m[b][j] = rp_m[b][j+1]; lh_m[b][j] = lh_m[b][j+1];
                            ll_m[b][j] = ll_m[b][j+1]; lp_m[b][j] = lp_m[b][j+1];
                            conn_m[b][j] = conn_m[b][j+1];
                        end
                        fill_m[b] = 3'(n - 1);
                        r.status = cdt_pkg::ST_DONE;
                        break;
                    end
                end
            end
            cdt_pkg::CMD_LOOKUP: begin
                k = cdt_pkg::K_EXACT;
                s = find_slot(b, cdt_pkg::K_EXACT, 1'b1, 1'b1, 1'b1, rh, rl, rp, lh, ll, lp);
                if (s < 0) begin
                    k = cdt_pkg::K_PA; b = bucket_of(8'd0, 16'd0, ll[7:0], lp);
                    s = find_slot(b, cdt_pkg::K_PA, 1'b0, 1'b1, 1'b1, rh, rl, rp, lh, ll, lp);
                end
                if (s < 0) begin
                    k = cdt_pkg::K_PORT; b = bucket_of(8'd0, 16'd0, 8'd0, lp);
                    s = find_slot(b, cdt_pkg::K_PORT, 1'b0, 1'b0, 1'b1, rh, rl, rp, lh, ll, lp);
                end
                if (s < 0) begin
                    k = cdt_pkg::K_ADDR; b = bucket_of(8'd0, 16'd0, ll[7:0], 16'd0);
                    s = find_slot(b, cdt_pkg::K_ADDR, 1'b0, 1'b1, 1'b0, rh, rl, rp, lh, ll, lp);
                end
                if (s < 0) begin
                    k = cdt_pkg::K_ANY; b = bucket_of(8'd0, 16'd0, 8'd0, 16'd0);
                    s = find_slot(b, cdt_pkg::K_ANY, 1'b0, 1'b0, 1'b0, rh, rl, rp, lh, ll, lp);
                end
                if (s >= 0) begin
                    r.status = cdt_pkg::ST_DONE;
                    r.conn = conn_m[b][s];
                    r.kind = k;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("tb: mismatch %s got %0d want %0d", what, got, want);
        errors++;
    endtask

    // one command transfer, with random idle cycles ahead of it
    task automatic send_cmd(cdt_pkg::t_cmd c, logic [63:0] rh, logic [63:0] rl,
                            logic [15:0] rp, logic [63:0] lh, logic [63:0] ll,
                            logic [15:0] lp, logic [9:0] id);
        while ($urandom_range(99) < send_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_command <= c;
        i_remote_addr_hi <= rh; i_remote_addr_lo <= rl; i_remote_port <= rp;
        i_local_addr_hi <= lh; i_local_addr_lo <= ll; i_local_port <= lp;
        i_conn_id <= id;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        resp_q.push_back(table_step(c, rh, rl, rp, lh, ll, lp, id));
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (resp_q.size() != 0) @(posedge i_clk);
    endtask

    // random field values leaning on the pools and on zero
    function automatic logic [63:0] pick64(bit lo, int zero_pct);
        int r;
        r = $urandom_range(99);
        if (r < zero_pct) return 64'd0;
        if (r < 85) return lo ? pool_lo[$urandom_range(3)] : pool_hi[$urandom_range(3)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] pick_port();
        int r;
        r = $urandom_range(99);
        if (r < 20) return 16'd0;
        if (r < 85) return pool_port[$urandom_range(3)];
        return 16'($urandom);
    endfunction

    task automatic test_directed();
        logic [63:0] ones;
        ones = '1;
        // each kind inserted then looked up
        send_cmd(cdt_pkg::CMD_INSERT, ones, ones, 16'hffff, ones, ones, 16'hffff, 10'h3ff);
        send_cmd(cdt_pkg::CMD_LOOKUP, ones, ones, 16'hffff, ones, ones, 16'hffff, 10'd0);
        send_cmd(cdt_pkg::CMD_INSERT, '0, '0, '0, 64'h5, 64'h12, 16'd80, 10'd11);
        send_cmd(cdt_pkg::CMD_INSERT, '0, '0, '0, '0, '0, 16'd80, 10'd12);
        send_cmd(cdt_pkg::CMD_INSERT, '0, '0, '0, 64'h5, 64'h12, 16'd0, 10'd13);
        send_cmd(cdt_pkg::CMD_INSERT, '0, '0, '0, '0, '0, 16'd0, 10'd14);
        send_cmd(cdt_pkg::CMD_LOOKUP, 64'h7, 64'h9, 16'd5, 64'h5, 64'h12, 16'd80, 10'd0);
        send_cmd(cdt_pkg::CMD_LOOKUP, 64'h7, 64'h9, 16'd5, 64'h6, 64'h12, 16'd80, 10'd0);
        send_cmd(cdt_pkg::CMD_LOOKUP, 64'h7, 64'h9, 16'd5, 64'h5, 64'h12, 16'd81, 10'd0);
        send_cmd(cdt_pkg::CMD_LOOKUP, 64'h7, 64'h9, 16'd5, 64'h1, 64'h2, 16'd3, 10'd0);
        // full bucket and duplicates
        repeat (5) send_cmd(cdt_pkg::CMD_INSERT, '0, '0, '0, '0, '0, 16'd0, 10'd20);
        send_cmd(cdt_pkg::CMD_REMOVE, '0, '0, '0, '0, '0, 16'd0, 10'd14);
        send_cmd(cdt_pkg::CMD_REMOVE, '0, '0, '0, '0, '0, 16'd0, 10'd999);
        send_cmd(cdt_pkg::CMD_UNUSED, ones, '0, 16'd1, '0, ones, 16'd1, 10'd1);
        send_cmd(cdt_pkg::CMD_REMOVE, ones, ones, 16'hffff, ones, ones, 16'hffff, 10'h3ff);
        send_cmd(cdt_pkg::CMD_LOOKUP, ones, ones, 16'hffff, ones, ones, 16'hffff, 10'd0);
        wait_drained();
    endtask

    task automatic test_random(int count);
        cdt_pkg::t_cmd c;
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            c = (r < 35) ? cdt_pkg::CMD_INSERT : (r < 60) ? cdt_pkg::CMD_REMOVE
                : (r < 97) ? cdt_pkg::CMD_LOOKUP : cdt_pkg::CMD_UNUSED;
            send_cmd(c, pick64(1'b0, 40), pick64(1'b1, 40), pick_port(), pick64(1'b0, 30),
                     pick64(1'b1, 30), pick_port(),
                     10'($urandom_range(c == cdt_pkg::CMD_REMOVE ? 15 : 1023)
                     | ($urandom_range(3) == 0 ? 10'($urandom) : 10'd0)));
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n && o_done) begin
            if (resp_q.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, -1);
            end else begin
                want = resp_q.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_found_conn !== want.conn) report_mismatch("found_conn", o_found_conn,
                                                                want.conn);
                if (o_match_kind !== want.kind) report_mismatch("match_kind", o_match_kind,
                                                                want.kind);
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !o_busy)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        send_idle_pct = 0;
        for (int b = 0; b < NB; b++) fill_m[b] = '0;
        for (int i = 0; i < 4; i++) begin
            pool_hi[i] = {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
            pool_port[i] = 16'($urandom);
        end
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_command <= cdt_pkg::CMD_INSERT;
        i_remote_addr_hi <= '0; i_remote_addr_lo <= '0; i_remote_port <= '0;
        i_local_addr_hi <= '0; i_local_addr_lo <= '0; i_local_port <= '0;
        i_conn_id <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        send_idle_pct = 28;
        test_random(450);
        wait_drained();     // sender holds off until the table is quiet
        send_idle_pct = 71;
        test_random(450);
        send_idle_pct = 0;
        test_random(450);

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (errors == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end
endmodule
